FILE: sv/stpg_pkg.sv
// Package with word types and codes shared by the stepper axis step generator.
`default_nettype none
package stpg_pkg;

    localparam int POS_WIDTH    = 32;
    localparam int TRAVEL_WIDTH = 31;
    localparam int CFG_IDX_W    = 2;
    localparam int MIN_INTERVAL = 20;
    localparam int RESET_MOVE_INTERVAL = 160;
    localparam int RESET_HOME_INTERVAL = 900;
    localparam int RESET_TRAVEL = 100000;

    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_ENABLE = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_ZERO   = 3'd3;
    localparam logic [2:0] CMD_HOME   = 3'd4;
    localparam logic [2:0] CMD_GOTO   = 3'd5;
    localparam logic [2:0] CMD_MOVE   = 3'd6;
    localparam logic [2:0] CMD_JOG    = 3'd7;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_DONE     = 3'd1;
    localparam logic [2:0] EV_MIN_STOP = 3'd2;
    localparam logic [2:0] EV_MAX_STOP = 3'd3;
    localparam logic [2:0] EV_FAULT    = 3'd4;
    localparam logic [2:0] EV_HOMED    = 3'd5;
    localparam logic [2:0] EV_CMD_STOP = 3'd6;
    localparam logic [2:0] EV_DISABLED = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAVEL_LEN    = 2'd2;

    typedef struct packed {
        logic [2:0]                  cmd;
        logic signed [POS_WIDTH-1:0] value;
        logic                        low_limit;
        logic                        high_limit;
    } in_word_t;

    typedef struct packed {
        logic                        step_out;
        logic                        dir_out;
        logic                        drive_enable;
        logic                        is_moving;
        logic                        is_homed;
        logic                        is_homing;
        logic signed [POS_WIDTH-1:0] position_now;
        logic signed [POS_WIDTH-1:0] target_now;
        logic [2:0]                  event_res;
    } out_word_t;

endpackage
`default_nettype wire

FILE: sv/stpg_cfg.sv
// Configuration registers: step intervals with lower clamp and travel length.
`default_nettype none
module stpg_cfg #(
    parameter int INTERVAL_WIDTH = 20,
    parameter int CFG_WIDTH      = 31
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [stpg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_WIDTH-1:0]                  cfg_data,
    output logic      [INTERVAL_WIDTH-1:0]             move_interval,
    output logic      [INTERVAL_WIDTH-1:0]             home_interval,
    output logic      [stpg_pkg::TRAVEL_WIDTH-1:0]     travel_len
);

    logic [INTERVAL_WIDTH-1:0]         move_ival_reg;
    logic [INTERVAL_WIDTH-1:0]         home_ival_reg;
    logic [stpg_pkg::TRAVEL_WIDTH-1:0] travel_reg;
    logic [INTERVAL_WIDTH-1:0]         ival_wr;

    always_comb begin
        ival_wr = cfg_data[INTERVAL_WIDTH-1:0];
        if (ival_wr < INTERVAL_WIDTH'(stpg_pkg::MIN_INTERVAL)) begin
            ival_wr = INTERVAL_WIDTH'(stpg_pkg::MIN_INTERVAL);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            move_ival_reg <= INTERVAL_WIDTH'(stpg_pkg::RESET_MOVE_INTERVAL);
            home_ival_reg <= INTERVAL_WIDTH'(stpg_pkg::RESET_HOME_INTERVAL);
            travel_reg    <= stpg_pkg::TRAVEL_WIDTH'(stpg_pkg::RESET_TRAVEL);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                stpg_pkg::CFG_MOVE_INTERVAL: move_ival_reg <= ival_wr;
                stpg_pkg::CFG_HOME_INTERVAL: home_ival_reg <= ival_wr;
                stpg_pkg::CFG_TRAVEL_LEN:    travel_reg <= cfg_data[stpg_pkg::TRAVEL_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign move_interval = move_ival_reg;
    assign home_interval = home_ival_reg;
    assign travel_len    = travel_reg;

endmodule
`default_nettype wire

FILE: sv/stpg_axis.sv
// Axis state registers and the per-word step, endstop and command logic.
`default_nettype none
module stpg_axis #(
    parameter int INTERVAL_WIDTH  = 20,
    parameter int STEP_HOLD_TICKS = 5
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              advance,
    input  wire stpg_pkg::in_word_t                in_word,
    input  wire logic [INTERVAL_WIDTH-1:0]         move_interval,
    input  wire logic [INTERVAL_WIDTH-1:0]         home_interval,
    input  wire logic [stpg_pkg::TRAVEL_WIDTH-1:0] travel_len,
    output stpg_pkg::out_word_t                    out_word
);

    localparam int PW = stpg_pkg::POS_WIDTH;

    logic                      enabled_reg, enabled_next;
    logic                      moving_reg, moving_next;
    logic                      homed_reg, homed_next;
    logic                      homing_reg, homing_next;
    logic                      cont_reg, cont_next;
    logic                      pulse_reg, pulse_next;
    logic                      sap_reg, sap_next;
    logic                      neg_reg, neg_next;
    logic [PW-1:0]             pos_reg, pos_next;
    logic [PW-1:0]             target_reg, target_next;
    logic [PW-1:0]             steps_reg, steps_next;
    logic [INTERVAL_WIDTH-1:0] ival_reg, ival_next;
    logic [INTERVAL_WIDTH-1:0] wait_reg, wait_next;

    logic                      do_halt;
    logic                      start;
    logic                      bm_neg;
    logic                      bm_cont;
    logic [PW-1:0]             bm_steps;
    logic [INTERVAL_WIDTH-1:0] bm_ival;
    logic [PW-1:0]             delta;
    logic [2:0]                ev;
    logic                      minh;
    logic                      maxh;

    always_comb begin
        enabled_next = enabled_reg;
        moving_next  = moving_reg;
        homed_next   = homed_reg;
        homing_next  = homing_reg;
        cont_next    = cont_reg;
        pulse_next   = pulse_reg;
        sap_next     = sap_reg;
        neg_next     = neg_reg;
        pos_next     = pos_reg;
        target_next  = target_reg;
        steps_next   = steps_reg;
        ival_next    = ival_reg;
        wait_next    = wait_reg;
        do_halt      = 1'b0;
        start        = 1'b0;
        bm_neg       = 1'b0;
        bm_cont      = 1'b0;
        bm_steps     = '0;
        bm_ival      = move_interval;
        delta        = '0;
        ev           = stpg_pkg::EV_NONE;
        minh         = in_word.low_limit;
        maxh         = in_word.high_limit;

        case (in_word.cmd)
            stpg_pkg::CMD_TICK: begin
                if (moving_reg && enabled_reg) begin
                    if (pulse_reg) begin
                        if (wait_reg <= INTERVAL_WIDTH'(1)) begin
                            pulse_next = 1'b0;
                            wait_next  = ival_reg;
                            if (sap_reg) begin
                                do_halt = 1'b1;
                                ev      = stpg_pkg::EV_DONE;
                            end
                        end else begin
                            wait_next = wait_reg - INTERVAL_WIDTH'(1);
                        end
                    end else if (wait_reg > INTERVAL_WIDTH'(1)) begin
                        wait_next = wait_reg - INTERVAL_WIDTH'(1);
                    end else if (neg_reg && minh) begin
                        ev       = homing_reg ? stpg_pkg::EV_HOMED : stpg_pkg::EV_MIN_STOP;
                        pos_next = '0;
                        if (homing_reg) begin
                            homed_next = 1'b1;
                        end
                        do_halt = 1'b1;
                    end else if (!neg_reg && maxh) begin
                        pos_next = PW'(travel_len);
                        do_halt  = 1'b1;
                        ev       = stpg_pkg::EV_MAX_STOP;
                    end else begin
                        pulse_next = 1'b1;
                        wait_next  = INTERVAL_WIDTH'(STEP_HOLD_TICKS);
                        pos_next   = neg_reg ? pos_reg - PW'(1) : pos_reg + PW'(1);
                        if (!cont_reg && steps_reg != '0) begin
                            steps_next = steps_reg - PW'(1);
                            if (steps_reg == PW'(1)) begin
                                sap_next = 1'b1;
                            end
                        end
                    end
                end
            end
            stpg_pkg::CMD_ENABLE: begin
                enabled_next = in_word.value[0];
                if (!in_word.value[0]) begin
                    do_halt = 1'b1;
                    ev      = stpg_pkg::EV_DISABLED;
                end
            end
            stpg_pkg::CMD_STOP: begin
                do_halt = 1'b1;
                ev      = stpg_pkg::EV_CMD_STOP;
            end
            stpg_pkg::CMD_ZERO: begin
                pos_next    = '0;
                target_next = '0;
                homed_next  = 1'b1;
            end
            stpg_pkg::CMD_HOME: begin
                if (minh && maxh) begin
                    ev = stpg_pkg::EV_FAULT;
                end else if (minh) begin
                    pos_next    = '0;
                    target_next = '0;
                    homed_next  = 1'b1;
                    ev          = stpg_pkg::EV_HOMED;
                end else begin
                    homed_next  = 1'b0;
                    homing_next = 1'b1;
                    start       = 1'b1;
                    bm_neg      = 1'b1;
                    bm_cont     = 1'b1;
                    bm_ival     = home_interval;
                end
            end
            stpg_pkg::CMD_GOTO: begin
                target_next = in_word.value;
                delta       = in_word.value - pos_reg;
                start       = 1'b1;
                bm_neg      = delta[PW-1];
                bm_steps    = delta[PW-1] ? (~delta + PW'(1)) : delta;
            end
            stpg_pkg::CMD_MOVE: begin
                target_next = pos_reg + in_word.value;
                delta       = in_word.value;
                start       = 1'b1;
                bm_neg      = delta[PW-1];
                bm_steps    = delta[PW-1] ? (~delta + PW'(1)) : delta;
            end
            stpg_pkg::CMD_JOG: begin
                start   = 1'b1;
                bm_neg  = in_word.value[PW-1];
                bm_cont = 1'b1;
            end
            default: ;
        endcase

        if (start && (bm_steps != '0 || bm_cont)) begin
            if (minh && maxh) begin
                do_halt = 1'b1;
                ev      = stpg_pkg::EV_FAULT;
            end else if (bm_neg && minh) begin
                do_halt = 1'b1;
                ev      = stpg_pkg::EV_MIN_STOP;
            end else if (!bm_neg && maxh) begin
                do_halt = 1'b1;
                ev      = stpg_pkg::EV_MAX_STOP;
            end else begin
                enabled_next = 1'b1;
                neg_next     = bm_neg;
                steps_next   = bm_steps;
                ival_next    = bm_ival;
                cont_next    = bm_cont;
                moving_next  = 1'b1;
                pulse_next   = 1'b0;
                sap_next     = 1'b0;
                wait_next    = '0;
            end
        end

        if (do_halt) begin
            moving_next = 1'b0;
            homing_next = 1'b0;
            cont_next   = 1'b0;
            pulse_next  = 1'b0;
            sap_next    = 1'b0;
            steps_next  = '0;
            wait_next   = '0;
            target_next = pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg <= 1'b0;
            moving_reg  <= 1'b0;
            homed_reg   <= 1'b0;
            homing_reg  <= 1'b0;
            cont_reg    <= 1'b0;
            pulse_reg   <= 1'b0;
            sap_reg     <= 1'b0;
            neg_reg     <= 1'b0;
            pos_reg     <= '0;
            target_reg  <= '0;
            steps_reg   <= '0;
            ival_reg    <= INTERVAL_WIDTH'(stpg_pkg::RESET_MOVE_INTERVAL);
            wait_reg    <= '0;
        end else if (advance) begin
            enabled_reg <= enabled_next;
            moving_reg  <= moving_next;
            homed_reg   <= homed_next;
            homing_reg  <= homing_next;
            cont_reg    <= cont_next;
            pulse_reg   <= pulse_next;
            sap_reg     <= sap_next;
            neg_reg     <= neg_next;
            pos_reg     <= pos_next;
            target_reg  <= target_next;
            steps_reg   <= steps_next;
            ival_reg    <= ival_next;
            wait_reg    <= wait_next;
        end
    end

    always_comb begin
        out_word.step_out     = pulse_next;
        out_word.dir_out      = neg_next;
        out_word.drive_enable = enabled_next;
        out_word.is_moving    = moving_next;
        out_word.is_homed     = homed_next;
        out_word.is_homing    = homing_next;
        out_word.position_now = pos_next;
        out_word.target_now   = target_next;
        out_word.event_res    = ev;
    end

endmodule
`default_nettype wire

FILE: sv/stepper_axis_step_generator.sv
// Top level of the stepper axis step generator: input and output registers, assertions.
//
// The s_ channel carries one word per tick (one microsecond elapsed) or per command.
// Every accepted word produces exactly one result word on the m_ channel carrying
// the step and direction pin levels, the enable, moving, homed and homing flags,
// the position, the target and an event code.
// A word is registered at the input, evaluated against the axis state, and its
// result is registered at the output, where it raises m_valid. One word is accepted
// every cycle while the result side keeps up.
// When the receiver stalls, the result holds in the output register and one more
// word waits in the input register; s_ready then drops until m_ready returns.
// The configuration port writes the move interval, the home interval and the travel
// length; interval writes below 20 clamp to 20, and a new interval takes effect when
// the next motion starts.
// Reset clears all flags, the position and target, and loads the register
// defaults of 160, 900 and 100000; no word is pending after reset.
`default_nettype none
module stepper_axis_step_generator #(
    parameter  int INTERVAL_WIDTH  = 20,
    parameter  int STEP_HOLD_TICKS = 5,
    localparam int CFG_WIDTH = (INTERVAL_WIDTH > stpg_pkg::TRAVEL_WIDTH) ?
                               INTERVAL_WIDTH : stpg_pkg::TRAVEL_WIDTH
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire stpg_pkg::in_word_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output stpg_pkg::out_word_t                 m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [stpg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_WIDTH-1:0]           cfg_data
);

    logic                              in_valid_reg;
    stpg_pkg::in_word_t                in_word_reg;
    logic                              out_valid_reg;
    stpg_pkg::out_word_t               out_word_reg;
    stpg_pkg::out_word_t               result;
    logic                              advance;
    logic [INTERVAL_WIDTH-1:0]         move_interval;
    logic [INTERVAL_WIDTH-1:0]         home_interval;
    logic [stpg_pkg::TRAVEL_WIDTH-1:0] travel_len;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    stpg_cfg #(
        .INTERVAL_WIDTH (INTERVAL_WIDTH),
        .CFG_WIDTH      (CFG_WIDTH)
    ) u_cfg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .move_interval (move_interval),
        .home_interval (home_interval),
        .travel_len    (travel_len)
    );

    stpg_axis #(
        .INTERVAL_WIDTH  (INTERVAL_WIDTH),
        .STEP_HOLD_TICKS (STEP_HOLD_TICKS)
    ) u_axis (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .in_word       (in_word_reg),
        .move_interval (move_interval),
        .home_interval (home_interval),
        .travel_len    (travel_len),
        .out_word      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_word_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

`ifndef NO_ASSERTIONS
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("Evaluated word did not reach the output register.");

    a_step_needs_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.step_out) |-> m_data.is_moving)
        else $error("Step pin high while the axis is not moving.");

    a_homing_needs_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_homing) |-> m_data.is_moving)
        else $error("Homing flagged while the axis is not moving.");

    a_disable_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.event_res == stpg_pkg::EV_DISABLED)
            |-> (!m_data.drive_enable && !m_data.is_moving))
        else $error("Disable event left the axis enabled or moving.");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/stepper_axis_step_generator_test.sv
// Self-checking testbench for the stepper axis step generator, with a predicting scoreboard.
`default_nettype none
module stepper_axis_step_generator_test;
    import stpg_pkg::*;

    localparam int IVAL_W     = 20;
    localparam int STEP_HOLD  = 5;
    localparam int CFG_W      = TRAVEL_WIDTH;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_word_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_word_t            m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    bit calm = 1'b0;
    int counted = 0;
    int phase_goal = 0;

    class axis_scoreboard;
        logic [IVAL_W-1:0] move_ival, home_ival, ival;
        logic [CFG_W-1:0]  travel;
        bit                en, moving, homed, homing, cont, pulse, stop_pend, neg;
        logic [31:0]       pos, tgt, left;
        logic [20:0]       wait_cnt;
        out_word_t         expected_words[$];
        int                errors;

        function new();
            move_ival = IVAL_W'(RESET_MOVE_INTERVAL);
            home_ival = IVAL_W'(RESET_HOME_INTERVAL);
            travel    = CFG_W'(RESET_TRAVEL);
            ival      = IVAL_W'(RESET_MOVE_INTERVAL);
            en = 0; moving = 0; homed = 0; homing = 0;
            cont = 0; pulse = 0; stop_pend = 0; neg = 0;
            pos = '0; tgt = '0; left = '0; wait_cnt = '0;
            errors = 0;
        endfunction

        function logic [IVAL_W-1:0] clamp_ival(logic [CFG_W-1:0] d);
            logic [IVAL_W-1:0] m;
            m = d[IVAL_W-1:0];
            return (m < IVAL_W'(MIN_INTERVAL)) ? IVAL_W'(MIN_INTERVAL) : m;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                CFG_MOVE_INTERVAL: move_ival = clamp_ival(d);
                CFG_HOME_INTERVAL: home_ival = clamp_ival(d);
                CFG_TRAVEL_LEN:    travel = d;
                default: ;
            endcase
        endfunction

        function void halt_axis();
            moving = 0; homing = 0; cont = 0; pulse = 0; stop_pend = 0;
            left = '0; wait_cnt = '0;
            tgt = pos;
        endfunction

        function logic [2:0] start_motion(bit n, logic [31:0] steps, logic [IVAL_W-1:0] iv,
                                          bit c, bit mn, bit mx);
            if (steps == 0 && !c) return EV_NONE;
            if (mn && mx) begin
                halt_axis();
                return EV_FAULT;
            end
            if (n && mn) begin
                halt_axis();
                return EV_MIN_STOP;
            end
            if (!n && mx) begin
                halt_axis();
                return EV_MAX_STOP;
            end
            en = 1; neg = n; left = steps; ival = iv; cont = c;
            moving = 1; pulse = 0; stop_pend = 0; wait_cnt = '0;
            return EV_NONE;
        endfunction

        function logic [2:0] step_tick(bit mn, bit mx);
            logic [2:0] r;
            if (!moving || !en) return EV_NONE;
            if (pulse) begin
                if (wait_cnt <= 1) begin
                    pulse = 0;
                    wait_cnt = 21'(ival);
                    if (stop_pend) begin
                        halt_axis();
                        return EV_DONE;
                    end
                end else begin
                    wait_cnt = wait_cnt - 1'b1;
                end
                return EV_NONE;
            end
            if (wait_cnt > 1) begin
                wait_cnt = wait_cnt - 1'b1;
                return EV_NONE;
            end
            if (neg && mn) begin
                r = homing ? EV_HOMED : EV_MIN_STOP;
                pos = '0;
                if (homing) homed = 1;
                halt_axis();
                return r;
            end
            if (!neg && mx) begin
                pos = {1'b0, travel};
                halt_axis();
                return EV_MAX_STOP;
            end
            pulse = 1;
            wait_cnt = 21'(STEP_HOLD);
            pos = neg ? pos - 32'd1 : pos + 32'd1;
            if (!cont && left > 0) begin
                left = left - 32'd1;
                if (left == 0) stop_pend = 1;
            end
            return EV_NONE;
        endfunction

        function logic [2:0] aim_delta(logic [31:0] delta, bit mn, bit mx);
            bit n;
            n = delta[31];
            return start_motion(n, n ? (32'd0 - delta) : delta, move_ival, 0, mn, mx);
        endfunction

        function void note_word(in_word_t w);
            logic [2:0]  ev;
            logic [31:0] v;
            bit          mn, mx;
            out_word_t   e;
            v = w.value;
            mn = w.low_limit;
            mx = w.high_limit;
            ev = EV_NONE;
            case (w.cmd)
                CMD_TICK: ev = step_tick(mn, mx);
                CMD_ENABLE: begin
                    en = v[0];
                    if (!en) begin
                        halt_axis();
                        ev = EV_DISABLED;
                    end
                end
                CMD_STOP: begin
                    halt_axis();
                    ev = EV_CMD_STOP;
                end
                CMD_ZERO: begin
                    pos = '0; tgt = '0; homed = 1;
                end
                CMD_HOME: begin
                    if (mn && mx) begin
                        ev = EV_FAULT;
                    end else if (mn) begin
                        pos = '0; tgt = '0; homed = 1;
                        ev = EV_HOMED;
                    end else begin
                        homed = 0;
                        homing = 1;
                        ev = start_motion(1, '0, home_ival, 1, mn, mx);
                    end
                end
                CMD_GOTO: begin
                    tgt = v;
                    ev = aim_delta(v - pos, mn, mx);
                end
                CMD_MOVE: begin
                    tgt = pos + v;
                    ev = aim_delta(v, mn, mx);
                end
                default: ev = start_motion(v[31], '0, move_ival, 1, mn, mx);
            endcase
            e.step_out     = pulse;
            e.dir_out      = neg;
            e.drive_enable = en;
            e.is_moving    = moving;
            e.is_homed     = homed;
            e.is_homing    = homing;
            e.position_now = pos;
            e.target_now   = tgt;
            e.event_res    = ev;
            expected_words.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            if (errors < 200) $display("mismatch: %s got %0h expected %0h", what, got, want);
            errors++;
        endtask

        task check_word(out_word_t got);
            out_word_t e;
            if (expected_words.size() == 0) begin
                report("result word with nothing expected", got.position_now, '0);
                return;
            end
            e = expected_words.pop_front();
            if (got.step_out !== e.step_out)
                report("step_out", 32'(got.step_out), 32'(e.step_out));
            if (got.dir_out !== e.dir_out)
                report("dir_out", 32'(got.dir_out), 32'(e.dir_out));
            if (got.drive_enable !== e.drive_enable)
                report("drive_enable", 32'(got.drive_enable), 32'(e.drive_enable));
            if (got.is_moving !== e.is_moving)
                report("is_moving", 32'(got.is_moving), 32'(e.is_moving));
            if (got.is_homed !== e.is_homed)
                report("is_homed", 32'(got.is_homed), 32'(e.is_homed));
            if (got.is_homing !== e.is_homing)
                report("is_homing", 32'(got.is_homing), 32'(e.is_homing));
            if (got.position_now !== e.position_now)
                report("position_now", got.position_now, e.position_now);
            if (got.target_now !== e.target_now)
                report("target_now", got.target_now, e.target_now);
            if (got.event_res !== e.event_res)
                report("event_res", 32'(got.event_res), 32'(e.event_res));
        endtask
    endclass

    axis_scoreboard sb = new();

    stepper_axis_step_generator #(
        .INTERVAL_WIDTH (IVAL_W),
        .STEP_HOLD_TICKS(STEP_HOLD)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

    initial begin : result_side
        int taken;
        int hold_left;
        bit held;
        taken = 0;
        hold_left = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_word(m_data);
                taken++;
            end
            if (!held && taken >= 350 && s_valid) begin
                held = 1;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
            end
        end
    end

    function automatic in_word_t word_of(logic [2:0] c, logic [31:0] v, bit mn, bit mx);
        in_word_t w;
        w.cmd = c;
        w.value = v;
        w.low_limit = mn;
        w.high_limit = mx;
        return w;
    endfunction

    task send_word(in_word_t w);
        bit counts;
        counts = !(w.cmd == CMD_TICK && !sb.moving);
        while (!calm && $urandom_range(99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        if (counts) counted++;
    endtask

    task program_axis(logic [CFG_W-1:0] mi, logic [CFG_W-1:0] hi, logic [CFG_W-1:0] ts);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MOVE_INTERVAL;
        cfg_data <= mi;
        @(posedge aclk);
        sb.set_reg(CFG_MOVE_INTERVAL, mi);
        cfg_index <= CFG_HOME_INTERVAL;
        cfg_data <= hi;
        @(posedge aclk);
        sb.set_reg(CFG_HOME_INTERVAL, hi);
        cfg_index <= CFG_TRAVEL_LEN;
        cfg_data <= ts;
        @(posedge aclk);
        sb.set_reg(CFG_TRAVEL_LEN, ts);
        cfg_index <= CFG_SPARE;
        cfg_data <= CFG_W'($urandom);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task settle();
        s_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task tick_burst(int max_ticks, int trip_at, bit mn_trip, bit mx_trip);
        bit mn, mx;
        for (int i = 0; i < max_ticks && sb.moving && counted < phase_goal; i++) begin
            mn = (i >= trip_at && mn_trip) ^ ($urandom_range(99) < 3);
            mx = (i >= trip_at && mx_trip) ^ ($urandom_range(99) < 3);
            send_word(word_of(CMD_TICK, $urandom, mn, mx));
        end
    endtask

    task start_random_motion();
        logic [31:0] d;
        bit mn, mx;
        d = $urandom_range(1, 4);
        mn = ($urandom_range(9) == 0);
        mx = ($urandom_range(9) == 0);
        case ($urandom_range(3))
            0: send_word(word_of(CMD_GOTO, $urandom_range(1) ? sb.pos + d : sb.pos - d, mn, mx));
            1: send_word(word_of(CMD_MOVE, $urandom_range(1) ? d : 32'd0 - d, mn, mx));
            2: send_word(word_of(CMD_JOG, $urandom, mn, mx));
            default: send_word(word_of(CMD_MOVE, $urandom, mn, mx));
        endcase
    endtask

    task random_phase(int n);
        int pick;
        int trip;
        phase_goal = counted + n;
        while (counted < phase_goal) begin
            pick = $urandom_range(99);
            trip = ($urandom_range(2) == 0) ? $urandom_range(0, 120) : 100000;
            if (pick < 40) begin
                if (!sb.en || $urandom_range(9) == 0)
                    send_word(word_of(CMD_ENABLE, $urandom | 32'd1, 0, 0));
                start_random_motion();
                case ($urandom_range(2))
                    0: tick_burst(200, trip, 1, 0);
                    1: tick_burst(200, trip, 0, 1);
                    default: tick_burst(200, trip, 1, 1);
                endcase
            end else if (pick < 60) begin
                send_word(word_of(CMD_HOME, $urandom, $urandom_range(99) < 15,
                                  $urandom_range(99) < 15));
                tick_burst(300, $urandom_range(0, 150), 1, 0);
            end else if (pick < 75) begin
                start_random_motion();
                tick_burst($urandom_range(0, 40), 100000, 0, 0);
                send_word(word_of(3'($urandom_range(1, 7)), $urandom, 1'($urandom_range(1)),
                                  1'($urandom_range(1))));
                tick_burst($urandom_range(0, 60), trip, 1, 1);
            end else begin
                repeat ($urandom_range(1, 5))
                    send_word(word_of(3'($urandom_range(7)), $urandom, 1'($urandom_range(1)),
                                      1'($urandom_range(1))));
            end
        end
    endtask

    task directed_words();
        send_word(word_of(CMD_TICK, 32'h0, 0, 0));
        send_word(word_of(CMD_ENABLE, 32'h0, 0, 0));
        send_word(word_of(CMD_ENABLE, 32'h8000_0001, 0, 0));
        send_word(word_of(CMD_GOTO, 32'h0, 0, 0));
        send_word(word_of(CMD_MOVE, 32'h0, 1, 1));
        send_word(word_of(CMD_ZERO, 32'hFFFF_FFFF, 0, 0));
        send_word(word_of(CMD_HOME, 32'h0, 1, 1));
        send_word(word_of(CMD_HOME, 32'h0, 1, 0));
        send_word(word_of(CMD_GOTO, 32'd5, 1, 1));
        send_word(word_of(CMD_MOVE, 32'hFFFF_FFFD, 1, 0));
        send_word(word_of(CMD_MOVE, 32'd3, 0, 1));
        send_word(word_of(CMD_JOG, 32'h7FFF_FFFF, 0, 1));
        send_word(word_of(CMD_JOG, 32'h8000_0000, 0, 0));
        send_word(word_of(CMD_TICK, 32'hFFFF_FFFF, 0, 0));
        send_word(word_of(CMD_STOP, 32'h0, 0, 0));
        send_word(word_of(CMD_GOTO, 32'h7FFF_FFFF, 0, 0));
        send_word(word_of(CMD_TICK, 32'h0, 0, 0));
        send_word(word_of(CMD_MOVE, 32'hFFFF_FFFF, 0, 0));
        send_word(word_of(CMD_HOME, 32'h0, 0, 0));
        send_word(word_of(CMD_ZERO, 32'h0, 0, 0));
        send_word(word_of(CMD_STOP, 32'h0, 0, 0));
        send_word(word_of(CMD_GOTO, 32'h8000_0000, 0, 0));
        send_word(word_of(CMD_ENABLE, 32'hFFFF_FFFE, 0, 0));
        send_word(word_of(CMD_TICK, 32'h0, 1, 1));
    endtask

    initial begin : stimulus
        int guard;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        directed_words();
        random_phase(60);
        settle();
        program_axis(CFG_W'(3), CFG_W'(20), CFG_W'(0));
        random_phase(250);
        settle();
        program_axis(CFG_W'('h7FF0_0015), CFG_W'(37), CFG_W'('h7FFF_FFFF));
        random_phase(200);
        settle();
        program_axis(CFG_W'('h000F_FFFF), CFG_W'('h7FFF_FFFF), CFG_W'($urandom));
        random_phase(50);
        settle();
        calm = 1'b1;
        program_axis(CFG_W'($urandom_range(20, 60)), CFG_W'($urandom_range(20, 60)),
                     CFG_W'($urandom));
        random_phase(200);
        calm = 1'b0;
        s_valid <= 1'b0;
        guard = 0;
        while (sb.expected_words.size() != 0 && guard < 20000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (8) @(posedge aclk);
        if (sb.expected_words.size() != 0)
            sb.report("result words never returned", sb.expected_words.size(), 0);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
